// ===== sv/rtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types, codes and constants for the 12-hour calendar clock.
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int unsigned SEC_W     = 7;
  localparam int unsigned MIN_W     = 6;
  localparam int unsigned HOUR_W    = 4;
  localparam int unsigned WDAY_W    = 3;
  localparam int unsigned YDAY_W    = 9;
  localparam int unsigned YEAR_W    = 16;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SEC_W-1:0]  SEC_MAX       = 7'd127;
  localparam logic [SEC_W-1:0]  SEC_PER_MIN   = 7'd60;
  localparam logic [SEC_W-1:0]  MIN_PER_HOUR  = 7'd60;
  localparam logic [SEC_W-1:0]  MIN_HALF      = 7'd30;
  localparam logic [SEC_W-1:0]  MIN_TWENTY    = 7'd20;
  localparam logic [SEC_W-1:0]  MIN_FIFTY     = 7'd50;
  localparam logic [HOUR_W:0]   HOUR_NOON     = 5'd12;
  localparam logic [HOUR_W-1:0] HOUR_FIRST    = 4'd1;
  localparam logic [HOUR_W-1:0] HOUR_RESET    = 4'd12;
  localparam logic [WDAY_W:0]   DAYS_PER_WEEK = 4'd7;
  localparam logic [YDAY_W:0]   YDAY_LIMIT    = 10'h16E;
  localparam logic [YDAY_W-1:0] YDAY_FIRST    = 9'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HALF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_MINUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOUR_MINUS = 2'd3;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_SEC_ROLL  = 3'd1,
    EV_HALF_HOUR = 3'd2,
    EV_PAIR_A    = 3'd3,
    EV_MIN_20_50 = 3'd4,
    EV_PAIR_B    = 3'd5
  } rtc_event_t;

  typedef enum logic [2:0] {
    FS_SEC   = 3'd0,
    FS_MIN   = 3'd1,
    FS_HOUR  = 3'd2,
    FS_PM    = 3'd3,
    FS_WDAY  = 3'd4,
    FS_YDAY  = 3'd5,
    FS_YEAR  = 3'd6,
    FS_LEAP  = 3'd7
  } rtc_field_t;

  typedef enum logic {
    KIND_ADVANCE = 1'b0,
    KIND_LOAD    = 1'b1
  } rtc_kind_t;

  typedef struct packed {
    logic [SEC_W-1:0]  sec;
    logic [MIN_W-1:0]  min;
    logic [HOUR_W-1:0] hour;
    logic              pm;
    logic [WDAY_W-1:0] wday;
    logic [YDAY_W-1:0] yday;
    logic [YEAR_W-1:0] year;
    logic              leap;
  } rtc_time_t;

  typedef struct packed {
    logic [CFG_W-1:0] base;
    logic [CFG_W-1:0] base_half;
    logic [CFG_W-1:0] half_minus;
    logic [CFG_W-1:0] hour_minus;
  } rtc_cfg_t;

endpackage

// ===== sv/rtc_tick.sv =====
// ----------------------------------------------------------------------------
// rtc_tick
// Next-state logic for one request: advance plus tick, or a field load.
// ----------------------------------------------------------------------------
module rtc_tick
  import rtc_pkg::*;
(
  input  rtc_time_t           cur,
  input  rtc_cfg_t            cfg,
  input  rtc_kind_t           kind,
  input  rtc_field_t          field_select,
  input  logic [VALUE_W-1:0]  value,
  output rtc_time_t           nxt,
  output rtc_event_t          event_code
);

  logic [VALUE_W:0]  sum;
  logic [SEC_W-1:0]  sec_sat;
  logic [SEC_W-1:0]  m;
  logic [HOUR_W:0]   h;
  logic [WDAY_W:0]   d;
  logic [YDAY_W:0]   yd;
  logic [YDAY_W:0]   limit;
  logic [YEAR_W-1:0] year_inc;
  logic              pm_new;

  assign sum      = {1'b0, value} + {{(VALUE_W+1-SEC_W){1'b0}}, cur.sec};
  assign sec_sat  = (sum > {{(VALUE_W+1-SEC_W){1'b0}}, SEC_MAX}) ? SEC_MAX : sum[SEC_W-1:0];
  assign m        = {1'b0, cur.min} + 7'd1;
  assign h        = {1'b0, cur.hour} + 5'd1;
  assign d        = {1'b0, cur.wday} + 4'd1;
  assign yd       = {1'b0, cur.yday} + 10'd1;
  assign limit    = YDAY_LIMIT + {{YDAY_W{1'b0}}, cur.leap};
  assign year_inc = cur.year + 16'd1;
  assign pm_new   = ~cur.pm;

  always_comb begin
    nxt        = cur;
    event_code = EV_NONE;
    if (kind == KIND_LOAD) begin
      unique case (field_select)
        FS_SEC:  nxt.sec  = value[SEC_W-1:0];
        FS_MIN:  nxt.min  = value[MIN_W-1:0];
        FS_HOUR: nxt.hour = value[HOUR_W-1:0];
        FS_PM:   nxt.pm   = value[0];
        FS_WDAY: nxt.wday = value[WDAY_W-1:0];
        FS_YDAY: nxt.yday = value[YDAY_W-1:0];
        FS_YEAR: nxt.year = value[YEAR_W-1:0];
        FS_LEAP: nxt.leap = value[0];
        default: nxt      = cur;
      endcase
    end else begin
      nxt.sec = sec_sat;
      if (sec_sat >= SEC_PER_MIN) begin
        nxt.sec = sec_sat - SEC_PER_MIN;
        nxt.min = m[MIN_W-1:0];
        if (m == MIN_HALF) begin
          event_code = EV_HALF_HOUR;
        end else if (m >= MIN_PER_HOUR) begin
          event_code = EV_HALF_HOUR;
          nxt.min    = '0;
          nxt.hour   = h[HOUR_W-1:0];
          if (h > HOUR_NOON) begin
            nxt.hour = HOUR_FIRST;
          end else if (h == HOUR_NOON) begin
            nxt.pm = pm_new;
            // midnight: roll the day
            if (!pm_new) begin
              nxt.wday = (d == DAYS_PER_WEEK) ? '0 : d[WDAY_W-1:0];
              if (yd >= limit) begin
                nxt.year = year_inc;
                nxt.yday = YDAY_FIRST;
                nxt.leap = (year_inc[1:0] == 2'b00);
              end else begin
                nxt.yday = yd[YDAY_W-1:0];
              end
            end
          end
        end else if (m == {1'b0, cfg.base} || m == {1'b0, cfg.base_half}) begin
          event_code = EV_PAIR_B;
        end else if (m == MIN_TWENTY || m == MIN_FIFTY) begin
          event_code = EV_MIN_20_50;
        end else if (m == {1'b0, cfg.half_minus} || m == {1'b0, cfg.hour_minus}) begin
          event_code = EV_PAIR_A;
        end else begin
          event_code = EV_SEC_ROLL;
        end
      end
    end
  end

endmodule

// ===== sv/rtc_calendar_tick_events.sv =====
// ----------------------------------------------------------------------------
// rtc_calendar_tick_events
// 12-hour real-time clock with calendar counters and minute event codes.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  request  | in_valid / in_stall    | kind, field_select, value
//  result   | out_valid / out_stall  | event_code, *_now snapshot
//  config   | cfg_we                 | cfg_index, cfg_data
//
//  One request per cycle sustained while out_stall is low. A request waits in
//  the input register, then the next-state logic updates the clock state and
//  the result register together, so back-to-back requests see each other's
//  state updates.
//  rst (synchronous) clears both valid bits, the clock fields to their
//  power-up time (12:00:00 AM, day 1, year 0, leap) and the config registers.
//  A stalled result holds; the input register keeps filling until the
//  result register is occupied and stalled, then in_stall rises.
//
module rtc_calendar_tick_events
  import rtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic [2:0]           field_select,
  input  logic [VALUE_W-1:0]   value,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           event_code,
  output logic [SEC_W-1:0]     seconds_now,
  output logic [MIN_W-1:0]     minutes_now,
  output logic [HOUR_W-1:0]    hours_now,
  output logic                 pm_now,
  output logic [WDAY_W-1:0]    weekday_now,
  output logic [YDAY_W-1:0]    yearday_now,
  output logic [YEAR_W-1:0]    year_now,
  output logic                 leap_now
);

  // config registers
  rtc_cfg_t cfg;

  // input register
  logic               req_valid;
  rtc_kind_t          req_kind;
  rtc_field_t         req_field;
  logic [VALUE_W-1:0] req_value;

  // clock state and result register
  rtc_time_t  clock_state;
  rtc_time_t  clock_state_next;
  rtc_event_t code_next;
  rtc_time_t  res_time;
  rtc_event_t res_code;
  logic       res_valid;

  logic res_load;   // result register free to take the request
  logic req_move;   // request leaves the input register this cycle

  assign res_load = !res_valid || !out_stall;
  assign req_move = req_valid && res_load;
  assign in_stall = req_valid && !res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE:       cfg.base       <= cfg_data;
        CFG_BASE_HALF:  cfg.base_half  <= cfg_data;
        CFG_HALF_MINUS: cfg.half_minus <= cfg_data;
        CFG_HOUR_MINUS: cfg.hour_minus <= cfg_data;
        default:        cfg            <= cfg;
      endcase
    end
  end

  // input register: takes a new request whenever it is empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_kind  <= rtc_kind_t'(kind);
      req_field <= rtc_field_t'(field_select);
      req_value <= value;
    end
  end

  rtc_tick u_tick (
    .cur          (clock_state),
    .cfg          (cfg),
    .kind         (req_kind),
    .field_select (req_field),
    .value        (req_value),
    .nxt          (clock_state_next),
    .event_code   (code_next)
  );

  // clock state commits only when the request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_state.sec  <= '0;
      clock_state.min  <= '0;
      clock_state.hour <= HOUR_RESET;
      clock_state.pm   <= 1'b0;
      clock_state.wday <= '0;
      clock_state.yday <= YDAY_FIRST;
      clock_state.year <= '0;
      clock_state.leap <= 1'b1;
    end else if (req_move) begin
      clock_state <= clock_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_move) begin
      res_time <= clock_state_next;
      res_code <= code_next;
    end
  end

  assign out_valid   = res_valid;
  assign event_code  = res_code;
  assign seconds_now = res_time.sec;
  assign minutes_now = res_time.min;
  assign hours_now   = res_time.hour;
  assign pm_now      = res_time.pm;
  assign weekday_now = res_time.wday;
  assign yearday_now = res_time.yday;
  assign year_now    = res_time.year;
  assign leap_now    = res_time.leap;

endmodule
